[design/acpc_pkg.sv]
// acpc_pkg: widths, lane count and shared types of the and-popcount counter
// no dependencies; compiled first
package acpc_pkg;

  localparam int unsigned LANES  = 3;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned PC_W   = $clog2(WORD_W + 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [PC_W-1:0]   pc_t;

  typedef logic [LANES-1:0][WORD_W-1:0] word_arr_t;
  typedef logic [LANES-1:0][CNT_W-1:0]  cnt_arr_t;

  // per-item control broadcast to the lanes and the output stage
  typedef struct packed {
    logic fire;  // an item is taken this cycle
    logic last;  // that item closes the row
  } acpc_ctrl_t;

endpackage

[design/acpc_if.sv]
// acpc_in_if / acpc_out_if: valid-ready channels of the and-popcount counter
// depends on acpc_pkg
interface acpc_in_if
  import acpc_pkg::*;
();
  logic  valid;
  logic  ready;
  word_t word_a;
  word_t word_b0;
  word_t word_b1;
  word_t word_b2;
  logic  last_word;

  modport source (output valid, word_a, word_b0, word_b1, word_b2, last_word,
                  input ready);
  modport sink   (input valid, word_a, word_b0, word_b1, word_b2, last_word,
                  output ready);
endinterface

interface acpc_out_if
  import acpc_pkg::*;
();
  logic valid;
  logic ready;
  cnt_t count_0;
  cnt_t count_1;
  cnt_t count_2;

  modport source (output valid, count_0, count_1, count_2, input ready);
  modport sink   (input valid, count_0, count_1, count_2, output ready);
endinterface

[design/and_popcount_three_column_counter_unit.sv]
// and_popcount_three_column_counter_unit: top level of the and-popcount counter
// depends on acpc_pkg, acpc_if, acpc_lane and acpc_merge
//
// usage
//   in_ch carries one item per row word: word_a of the current row and the
//   matching words of three fixed rows, plus last_word on the row's final
//   word. three lanes and word_a with each fixed word, count the ones and
//   add the count to a 32-bit running total that wraps modulo 2^32.
//   the item with last_word set produces one result on out_ch holding the
//   three totals including its own counts, and the totals restart at zero.
//   items without last_word produce no result.
//   throughput: one item per cycle while in_ch ready is high; the popcount
//   and add of each lane are combinational. a result is registered in the
//   output register when its last item is taken, or in the skid entry.
//   the result sits in an output register backed by one skid entry; in_ch
//   ready is low only while both hold results that out_ch has not taken,
//   so mid-row items keep streaming while one result waits.
//   reset (rst_n low, synchronous) clears the totals and empties the output
//   and skid entries; no clearing pass is needed.
module and_popcount_three_column_counter_unit
  import acpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  acpc_in_if.sink    in_ch,
  acpc_out_if.source out_ch
);

  acpc_ctrl_t ctrl;
  word_arr_t  b_words;
  cnt_arr_t   totals;
  logic       ready;

  // an item is taken when valid meets ready
  assign in_ch.ready = ready;
  assign ctrl.fire   = in_ch.valid && ready;
  assign ctrl.last   = in_ch.last_word;

  // fixed-row words in lane order
  assign b_words[0] = in_ch.word_b0;
  assign b_words[1] = in_ch.word_b1;
  assign b_words[2] = in_ch.word_b2;

  // one lane per fixed row
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    acpc_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .word_a (in_ch.word_a),
      .word_b (b_words[j]),
      .total  (totals[j])
    );
  end

  // merge the lane totals into the result item
  acpc_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .totals   (totals),
    .in_ready (ready),
    .out_ch   (out_ch)
  );

endmodule

[design/acpc_lane.sv]
// acpc_lane: one lane, and of two words, popcount and running total
// depends on acpc_pkg
module acpc_lane
  import acpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  acpc_ctrl_t ctrl,
  input  word_t      word_a,
  input  word_t      word_b,
  output cnt_t       total    // running total including this item's count
);

  // adder-tree popcount: pair, nibble and byte sums, then the bytes folded together
  function automatic pc_t popcount(input word_t v);
    word_t s2, s4, s8, s16, s32, s64;
    s2  = v - ((v >> 1) & {(WORD_W/2){2'b01}});
    s4  = (s2 & {(WORD_W/4){4'h3}}) + ((s2 >> 2) & {(WORD_W/4){4'h3}});
    s8  = (s4 + (s4 >> 4)) & {(WORD_W/8){8'h0f}};
    // low byte of each wider group holds its count, upper bytes are don't-care
    s16 = s8 + (s8 >> 8);
    s32 = s16 + (s16 >> 16);
    s64 = s32 + (s32 >> 32);
    return s64[PC_W-1:0];
  endfunction

  cnt_t acc_r, acc_nxt;
  pc_t  pc;

  assign pc    = popcount(word_a & word_b);
  assign total = acc_r + CNT_W'(pc);

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.fire) begin
      acc_nxt = ctrl.last ? '0 : total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // row end clears the total
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.fire && ctrl.last |=> acc_r == '0)
    else $error("lane total not cleared at row end");

  // idle cycles keep the total
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl.fire |=> $stable(acc_r))
    else $error("lane total changed without an item");

  // a mid-row item adds its count
  a_add: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.fire && !ctrl.last |=> acc_r == $past(total))
    else $error("lane total did not accumulate");

endmodule

[design/acpc_merge.sv]
// acpc_merge: gathers the lane totals into the result item, with skid buffer
// depends on acpc_pkg and acpc_out_if
module acpc_merge
  import acpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  acpc_ctrl_t        ctrl,
  input  cnt_arr_t          totals,
  output logic              in_ready,
  acpc_out_if.source        out_ch
);

  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  cnt_arr_t out_data_r, out_data_nxt;
  cnt_arr_t skid_data_r, skid_data_nxt;
  logic     push;

  assign push     = ctrl.fire && ctrl.last;
  assign in_ready = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        if (push) begin
          out_data_nxt = totals;
        end
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = totals;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.count_0 = out_data_r[0];
  assign out_ch.count_1 = out_data_r[1];
  assign out_ch.count_2 = out_data_r[2];

  // skid only fills behind a held output
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without output entry");

  // no result arrives while the skid is full
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("result pushed into full buffer");

  // a drained output refills from the skid
  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.ready && skid_valid_r |=> out_valid_r && !skid_valid_r)
    else $error("skid entry lost on drain");

endmodule

[sim/and_popcount_three_column_counter_unit_test.sv]
// and_popcount_three_column_counter_unit_test: self-checking bench for the and-popcount counter
// drives row words through in_ch, predicts the per-row shared-bit totals and checks out_ch
// depends on acpc_pkg, acpc_if and and_popcount_three_column_counter_unit
`timescale 1ns / 1ps

module and_popcount_three_column_counter_unit_test;
  import acpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    cnt_t count_0;
    cnt_t count_1;
    cnt_t count_2;
  } row_totals_t;

  logic clk = 1'b0;
  logic rst_n;

  acpc_in_if  in_ch ();
  acpc_out_if out_ch ();

  and_popcount_three_column_counter_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // shared-bit totals of the row in progress, and totals of closed rows not yet seen
  cnt_t        shared_totals [LANES];
  row_totals_t pending_row_totals[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;

  function automatic cnt_t ones_in(word_t w);
    cnt_t n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) n += w[i];
    return n;
  endfunction

  // fold one accepted row word into the totals; a closing word queues the row result
  function automatic void fold_row_word(word_t a, word_t b0, word_t b1, word_t b2,
                                        logic last);
    row_totals_t t;
    shared_totals[0] += ones_in(a & b0);
    shared_totals[1] += ones_in(a & b1);
    shared_totals[2] += ones_in(a & b2);
    if (last) begin
      t.count_0 = shared_totals[0];
      t.count_1 = shared_totals[1];
      t.count_2 = shared_totals[2];
      pending_row_totals.push_back(t);
      for (int j = 0; j < LANES; j++) shared_totals[j] = '0;
    end
  endfunction

  // result check and prediction, both on the rising edge
  always @(posedge clk) begin
    row_totals_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_row_totals.size() == 0) begin
        $error("row result with no row closed: %0d %0d %0d",
               out_ch.count_0, out_ch.count_1, out_ch.count_2);
        mismatch_count++;
      end else begin
        want = pending_row_totals.pop_front();
        if (out_ch.count_0 !== want.count_0) begin
          $error("count_0 expected %0d actual %0d", want.count_0, out_ch.count_0);
          mismatch_count++;
        end
        if (out_ch.count_1 !== want.count_1) begin
          $error("count_1 expected %0d actual %0d", want.count_1, out_ch.count_1);
          mismatch_count++;
        end
        if (out_ch.count_2 !== want.count_2) begin
          $error("count_2 expected %0d actual %0d", want.count_2, out_ch.count_2);
          mismatch_count++;
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready)
      fold_row_word(in_ch.word_a, in_ch.word_b0, in_ch.word_b1, in_ch.word_b2,
                    in_ch.last_word);
  end

  // result side backpressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic push_row_word(word_t a, word_t b0, word_t b1, word_t b2, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.word_a    <= a;
    in_ch.word_b0   <= b0;
    in_ch.word_b1   <= b1;
    in_ch.word_b2   <= b2;
    in_ch.last_word <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // mix of densities so both sparse and saturated ands show up
  function automatic word_t random_word();
    word_t r0, r1, r2;
    r0 = {$urandom, $urandom};
    r1 = {$urandom, $urandom};
    r2 = {$urandom, $urandom};
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return r0 & r1 & r2;
      3:       return r0 | r1;
      default: return r0;
    endcase
  endfunction

  // one-word rows: extremes, exclusive patterns and lone edge bits
  task automatic test_single_word_rows();
    push_row_word('1, '1, '1, '1, 1'b1);
    push_row_word('0, '0, '0, '0, 1'b1);
    push_row_word('1, '0, '1, {32{2'b10}}, 1'b1);
    push_row_word({32{2'b01}}, '1, {32{2'b10}}, {32{2'b01}}, 1'b1);
    push_row_word({1'b1, 62'd0, 1'b1}, '1, '1, '1, 1'b1);
    push_row_word('0, '1, '1, '1, 1'b1);
  endtask

  // rows spanning several words, incl. a saturated one
  task automatic test_multi_word_rows();
    for (int i = 0; i < 8; i++) push_row_word('1, '1, '1, '1, 1'b0);
    push_row_word('1, '1, '1, '1, 1'b1);
    for (int i = 0; i < 3; i++)
      push_row_word(random_word(), random_word(), random_word(), random_word(), 1'b0);
    push_row_word(random_word(), random_word(), random_word(), random_word(), 1'b1);
    push_row_word('1, {32{2'b10}}, '0, '1, 1'b0);
    push_row_word('1, {32{2'b01}}, '1, '0, 1'b1);
  endtask

  // whole rows of random length until the item budget is spent
  task automatic test_random_rows(int unsigned n_items, int unsigned src_pct,
                                  int unsigned snk_pct);
    int unsigned sent;
    int unsigned row_len;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      row_len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(6, 1);
      for (int unsigned k = 1; k <= row_len; k++)
        push_row_word(random_word(), random_word(), random_word(), random_word(),
                      k == row_len);
      sent += row_len;
    end
  endtask

  initial begin
    for (int j = 0; j < LANES; j++) shared_totals[j] = '0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.word_a    = '0;
    in_ch.word_b0   = '0;
    in_ch.word_b1   = '0;
    in_ch.word_b2   = '0;
    in_ch.last_word = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_single_word_rows();
    test_multi_word_rows();
    test_random_rows(360, 15, 58);
    test_random_rows(360, 58, 15);
    test_random_rows(380, 0, 0);
    in_ch.valid <= 1'b0;

    while (pending_row_totals.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
